// ===== sv/atan2_heading_unit_defines.svh =====
// Assertion macros for the heading unit.
// Used by the top level; depends on nothing else.
`ifndef ATAN2_HEADING_UNIT_DEFINES_SVH
`define ATAN2_HEADING_UNIT_DEFINES_SVH

// Same-cycle implication under the asynchronous reset.
`define AHU_ASSERT_IMPLY(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (c)) \
		else $error("assertion failed");

// Next-cycle implication under the asynchronous reset.
`define AHU_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (c)) \
		else $error("assertion failed");

`endif

// ===== sv/atan2h_pkg.sv =====
// Shared types, constants and helpers for the heading unit.
// Used by the datapath, the controller and the top level.
package atan2h_pkg;

	localparam int FRAC_BITS = 16;
	localparam int IFRAC = 30;
	localparam int ANGLE_W = FRAC_BITS + 3;
	localparam int HEAD_W = FRAC_BITS + 9;
	localparam int OUT_SHIFT = IFRAC - FRAC_BITS;
	localparam int WIDE_W = 42;
	localparam int RAD_W = 34;

	localparam logic signed [WIDE_W-1:0] K_PI =
		WIDE_W'(((64'd3141590 << IFRAC) + 64'd500000) / 64'd1000000);
	localparam logic signed [WIDE_W-1:0] K_HALF_PI =
		WIDE_W'(((64'd1570800 << IFRAC) + 64'd500000) / 64'd1000000);
	localparam logic signed [WIDE_W-1:0] K_THREE_HALF_PI =
		WIDE_W'(((64'd4712390 << IFRAC) + 64'd500000) / 64'd1000000);
	localparam logic signed [WIDE_W-1:0] K_QUARTER_PI =
		WIDE_W'(((64'd785398 << IFRAC) + 64'd500000) / 64'd1000000);
	localparam logic signed [WIDE_W-1:0] K_THREE_QUARTER_PI =
		WIDE_W'(((64'd2356190 << IFRAC) + 64'd500000) / 64'd1000000);
	localparam logic [35:0] K_RAD2DEG =
		36'(((64'd57295800 << IFRAC) + 64'd500000) / 64'd1000000);
	localparam logic signed [WIDE_W-1:0] DEG_90 = WIDE_W'(64'd90 << IFRAC);
	localparam logic signed [WIDE_W-1:0] DEG_180 = WIDE_W'(64'd180 << IFRAC);
	localparam logic signed [WIDE_W-1:0] DEG_270 = WIDE_W'(64'd270 << IFRAC);
	localparam logic signed [WIDE_W-1:0] DEG_360 = WIDE_W'(64'd360 << IFRAC);
	localparam logic [29:0] SERIES_FLOOR = 30'd107;
	// Reciprocal of three scaled by 2^33; exact for dividends below 2^32.
	localparam logic [35:0] RECIP_3 = 36'h0AAAAAAAB;

	localparam logic [4:0] OP_NONE = 5'd0;
	localparam logic [4:0] OP_LOAD = 5'd1;
	localparam logic [4:0] OP_DIV_T = 5'd2;
	localparam logic [4:0] OP_GET_T = 5'd3;
	localparam logic [4:0] OP_MUL_T2 = 5'd4;
	localparam logic [4:0] OP_DIV_Y = 5'd5;
	localparam logic [4:0] OP_GET_Y = 5'd6;
	localparam logic [4:0] OP_DIV_F = 5'd7;
	localparam logic [4:0] OP_GET_F = 5'd8;
	localparam logic [4:0] OP_DIV_3 = 5'd9;
	localparam logic [4:0] OP_GET_TERM0 = 5'd10;
	localparam logic [4:0] OP_ACC = 5'd11;
	localparam logic [4:0] OP_MUL_TY = 5'd12;
	localparam logic [4:0] OP_MUL_K = 5'd13;
	localparam logic [4:0] OP_DIV_K = 5'd14;
	localparam logic [4:0] OP_GET_TERM = 5'd15;
	localparam logic [4:0] OP_MUL_SF = 5'd16;
	localparam logic [4:0] OP_GET_ATAN = 5'd17;
	localparam logic [4:0] OP_RAD = 5'd18;
	localparam logic [4:0] OP_MUL_DEG = 5'd19;
	localparam logic [4:0] OP_HEAD = 5'd20;

	typedef struct packed {
		logic signed [23:0] delta_x;
		logic signed [23:0] delta_z;
	} req_t;

	typedef struct packed {
		logic signed [ANGLE_W-1:0] angle_rad;
		logic [HEAD_W-1:0] heading_deg;
		logic undefined_dir;
	} res_t;

	typedef struct packed {
		logic [4:0] op;
	} cmd_t;

	typedef struct packed {
		logic special;
		logic div_done;
		logic k_end;
		logic term_small;
	} stat_t;

	// Rounds a Q30 value to the output fraction, ties away from zero.
	function automatic logic [WIDE_W-1:0] to_out(input logic signed [WIDE_W-1:0] v);
		logic [WIDE_W-1:0] m;
		logic [WIDE_W-1:0] r;
		m = v[WIDE_W-1] ? WIDE_W'(-v) : WIDE_W'(v);
		r = (m + (WIDE_W'(1) << (OUT_SHIFT - 1))) >> OUT_SHIFT;
		if (v[WIDE_W-1]) begin
			r = ~r + WIDE_W'(1);
		end
		return r;
	endfunction

endpackage

// ===== sv/atan2_heading_unit.sv =====
// A zero, axis or diagonal vector skips the divisions and the series; any other vector
// runs its divisions, one per series term among them, through the one shared 32-step
// divider. One request at a time; busy is high until the result strobe, and the next
// request may start in the strobe cycle.
// Reset (arst_n low) returns the controller to idle and clears the strobe.
// Depends on atan2h_pkg, atan2h_ctrl, atan2h_dp and the assertion macros.
`include "atan2_heading_unit_defines.svh"
module atan2_heading_unit #(
	parameter int SERIES_LIMIT = 100
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  atan2h_pkg::req_t request,
	output atan2h_pkg::res_t result,
	output logic             done
);

	atan2h_pkg::cmd_t cmd;
	atan2h_pkg::stat_t stat;
	logic res_zero;

	atan2h_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	atan2h_dp #(
		.SERIES_LIMIT (SERIES_LIMIT)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.cmd     (cmd),
		.stat    (stat),
		.result  (result),
		.done    (done)
	);

	assign res_zero = result.angle_rad == '0 && result.heading_deg == '0;

	`AHU_ASSERT_IMPLY(a_done_idle, clk, arst_n, done, !busy)
	`AHU_ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy)
	`AHU_ASSERT_IMPLY(a_undef_zero, clk, arst_n, done && result.undefined_dir, res_zero)

endmodule

// ===== sv/atan2h_div.sv =====
// Restoring divider, one quotient bit per cycle, 32 quotient bits.
// Standalone; used by the datapath. The quotient must be below 2^32.
module atan2h_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	output logic [31:0] quotient,
	output logic        ready
);

	logic [31:0] rem_q;
	logic [31:0] low_q;
	logic [31:0] div_q;
	logic [4:0]  cnt_q;
	logic        active_q;
	logic        ready_q;
	logic [32:0] trial;
	logic        ge;

	assign trial = {rem_q, low_q[31]};
	assign ge = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			ready_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			ready_q <= 1'b0;
			if (go) begin
				active_q <= 1'b1;
				cnt_q <= 5'd31;
			end else if (active_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					active_q <= 1'b0;
					ready_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= dividend[63:32];
			low_q <= dividend[31:0];
			div_q <= divisor;
		end else if (active_q) begin
			rem_q <= ge ? 32'(trial - {1'b0, div_q}) : trial[31:0];
			low_q <= {low_q[30:0], ge};
		end
	end

	assign quotient = low_q;
	assign ready = ready_q;

endmodule

// ===== sv/atan2h_dp.sv =====
// Datapath: operand registers, shared multiplier, divider and output stage.
// Depends on atan2h_pkg and atan2h_div; driven by the controller's commands.
module atan2h_dp #(
	parameter int SERIES_LIMIT = 100
) (
	input  logic              clk,
	input  logic              arst_n,
	input  atan2h_pkg::req_t  request,
	input  atan2h_pkg::cmd_t  cmd,
	output atan2h_pkg::stat_t stat,
	output atan2h_pkg::res_t  result,
	output logic              done
);

	localparam int KW = $clog2(SERIES_LIMIT + 2);

	logic signed [23:0] x_q, z_q;
	logic [23:0] ax, az, num, den;
	logic [29:0] t_q, t2_q, y_q, f_q, term_q;
	logic [31:0] sum_q, atan_q;
	logic [KW-1:0] k_q;
	logic [63:0] prod_q;
	logic signed [atan2h_pkg::RAD_W-1:0] rad_q, rad_c;
	atan2h_pkg::res_t result_q;
	logic done_q;

	logic div_go;
	logic [63:0] dividend;
	logic [31:0] divisor, quotient;
	logic div_ready;
	logic [31:0] mul_a;
	logic [35:0] mul_b;
	logic [67:0] mul_p;
	logic [atan2h_pkg::RAD_W-1:0] rad_mag;

	assign ax = x_q[23] ? 24'(-x_q) : 24'(x_q);
	assign az = z_q[23] ? 24'(-z_q) : 24'(z_q);
	assign num = (az < ax) ? az : ax;
	assign den = (az < ax) ? ax : az;

	assign stat.special = (x_q == 24'sd0) || (z_q == 24'sd0) || (ax == az);
	assign stat.div_done = div_ready;
	assign stat.k_end = k_q >= KW'(SERIES_LIMIT);
	assign stat.term_small = term_q <= atan2h_pkg::SERIES_FLOOR;

	always_comb begin
		div_go = 1'b1;
		dividend = '0;
		divisor = 32'd1;
		case (cmd.op)
			atan2h_pkg::OP_DIV_T: begin
				dividend = {10'd0, num, 30'd0};
				divisor = {8'd0, den};
			end
			atan2h_pkg::OP_DIV_Y: begin
				dividend = {4'd0, prod_q[59:30], 30'd0};
				divisor = 32'(1 << atan2h_pkg::IFRAC) + {2'd0, prod_q[59:30]};
			end
			atan2h_pkg::OP_DIV_F: begin
				dividend = {4'd0, t_q, 30'd0};
				divisor = 32'(1 << atan2h_pkg::IFRAC) + {2'd0, t2_q};
			end
			atan2h_pkg::OP_DIV_K: begin
				dividend = prod_q;
				divisor = 32'(k_q) + 32'd1;
			end
			default: begin
				div_go = 1'b0;
			end
		endcase
	end

	atan2h_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (dividend),
		.divisor  (divisor),
		.quotient (quotient),
		.ready    (div_ready)
	);

	assign rad_mag = rad_q[atan2h_pkg::RAD_W-1] ? atan2h_pkg::RAD_W'(-rad_q)
		: atan2h_pkg::RAD_W'(rad_q);

	always_comb begin
		case (cmd.op)
			atan2h_pkg::OP_MUL_T2: begin
				mul_a = {2'd0, t_q};
				mul_b = {6'd0, t_q};
			end
			atan2h_pkg::OP_DIV_3: begin
				mul_a = {1'b0, y_q, 1'b0};
				mul_b = atan2h_pkg::RECIP_3;
			end
			atan2h_pkg::OP_MUL_TY: begin
				mul_a = {2'd0, term_q};
				mul_b = {6'd0, y_q};
			end
			atan2h_pkg::OP_MUL_K: begin
				mul_a = prod_q[61:30];
				mul_b = 36'(k_q);
			end
			atan2h_pkg::OP_MUL_SF: begin
				mul_a = sum_q;
				mul_b = {6'd0, f_q};
			end
			default: begin
				mul_a = 32'(rad_mag[atan2h_pkg::RAD_W-1:8]);
				mul_b = atan2h_pkg::K_RAD2DEG;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	always_comb begin
		logic signed [atan2h_pkg::RAD_W-1:0] v, vv, inner;
		logic a0neg, a1neg, a1pos, a0pos;
		v = {2'b00, atan_q};
		vv = '0;
		inner = '0;
		a0neg = 1'b0;
		a1neg = 1'b0;
		a0pos = 1'b0;
		a1pos = 1'b0;
		rad_c = '0;
		if (x_q == 24'sd0 && z_q == 24'sd0) begin
			rad_c = '0;
		end else if (z_q == 24'sd0) begin
			rad_c = (x_q > 24'sd0) ? '0 : atan2h_pkg::RAD_W'(atan2h_pkg::K_PI);
		end else if (x_q == 24'sd0) begin
			rad_c = (z_q > 24'sd0) ? atan2h_pkg::RAD_W'(atan2h_pkg::K_HALF_PI)
				: atan2h_pkg::RAD_W'(-atan2h_pkg::K_HALF_PI);
		end else if (ax == az) begin
			if (z_q[23] == x_q[23]) begin
				rad_c = (z_q > 24'sd0) ? atan2h_pkg::RAD_W'(atan2h_pkg::K_QUARTER_PI)
					: atan2h_pkg::RAD_W'(-atan2h_pkg::K_THREE_QUARTER_PI);
			end else begin
				rad_c = (x_q > 24'sd0) ? atan2h_pkg::RAD_W'(-atan2h_pkg::K_QUARTER_PI)
					: atan2h_pkg::RAD_W'(atan2h_pkg::K_THREE_QUARTER_PI);
			end
		end else begin
			if (az < ax) begin
				a0neg = z_q[23];
				a1neg = x_q[23];
			end else begin
				a0neg = x_q[23];
				a1neg = z_q[23];
			end
			a0pos = !a0neg;
			a1pos = !a1neg;
			vv = (a0neg != a1neg) ? -v : v;
			if (a1pos) begin
				inner = vv;
			end else if (a0pos) begin
				inner = atan2h_pkg::RAD_W'(atan2h_pkg::K_PI) + vv;
			end else begin
				inner = vv - atan2h_pkg::RAD_W'(atan2h_pkg::K_PI);
			end
			if (az < ax) begin
				rad_c = inner;
			end else if (x_q > 24'sd0 || z_q > 24'sd0) begin
				rad_c = atan2h_pkg::RAD_W'(atan2h_pkg::K_HALF_PI) - inner;
			end else begin
				rad_c = -atan2h_pkg::RAD_W'(atan2h_pkg::K_THREE_HALF_PI) - inner;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			atan2h_pkg::OP_LOAD: begin
				x_q <= request.delta_x;
				z_q <= request.delta_z;
			end
			atan2h_pkg::OP_GET_T: t_q <= quotient[29:0];
			atan2h_pkg::OP_DIV_Y: t2_q <= prod_q[59:30];
			atan2h_pkg::OP_GET_Y: y_q <= quotient[29:0];
			atan2h_pkg::OP_GET_F: f_q <= quotient[29:0];
			atan2h_pkg::OP_GET_TERM0: begin
				term_q <= prod_q[62:33];
				sum_q <= 32'(1 << atan2h_pkg::IFRAC);
				k_q <= KW'(4);
			end
			atan2h_pkg::OP_ACC: sum_q <= sum_q + {2'd0, term_q};
			atan2h_pkg::OP_GET_TERM: begin
				term_q <= quotient[29:0];
				k_q <= k_q + KW'(2);
			end
			atan2h_pkg::OP_GET_ATAN: atan_q <= prod_q[61:30];
			atan2h_pkg::OP_RAD: rad_q <= rad_c;
			default: begin
			end
		endcase
		if (cmd.op == atan2h_pkg::OP_MUL_T2 || cmd.op == atan2h_pkg::OP_MUL_TY ||
			cmd.op == atan2h_pkg::OP_MUL_K || cmd.op == atan2h_pkg::OP_MUL_SF ||
			cmd.op == atan2h_pkg::OP_MUL_DEG || cmd.op == atan2h_pkg::OP_DIV_3) begin
			prod_q <= mul_p[63:0];
		end
	end

	always_ff @(posedge clk) begin
		logic signed [atan2h_pkg::WIDE_W-1:0] deg, head;
		logic [atan2h_pkg::WIDE_W-1:0] ro, ho;
		if (cmd.op == atan2h_pkg::OP_HEAD) begin
			deg = atan2h_pkg::WIDE_W'(prod_q[59:22]);
			if (rad_q[atan2h_pkg::RAD_W-1]) begin
				deg = -deg;
			end
			head = atan2h_pkg::DEG_90 - deg;
			if (z_q > 24'sd0 && head[atan2h_pkg::WIDE_W-1]) begin
				head = head + atan2h_pkg::DEG_360;
			end
			if (x_q == 24'sd0) begin
				head = (z_q > 24'sd0) ? '0 : atan2h_pkg::DEG_180;
			end else if (z_q == 24'sd0) begin
				head = (x_q > 24'sd0) ? atan2h_pkg::DEG_90 : atan2h_pkg::DEG_270;
			end
			ro = atan2h_pkg::to_out(atan2h_pkg::WIDE_W'(rad_q));
			ho = atan2h_pkg::to_out(head);
			if (x_q == 24'sd0 && z_q == 24'sd0) begin
				result_q.angle_rad <= '0;
				result_q.heading_deg <= '0;
				result_q.undefined_dir <= 1'b1;
			end else begin
				result_q.angle_rad <= ro[atan2h_pkg::ANGLE_W-1:0];
				result_q.heading_deg <= ho[atan2h_pkg::HEAD_W-1:0];
				result_q.undefined_dir <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.op == atan2h_pkg::OP_HEAD;
		end
	end

	assign result = result_q;
	assign done = done_q;

endmodule

// ===== sv/atan2h_ctrl.sv =====
// Controller state machine sequencing divisions, products and the series.
// Depends on atan2h_pkg; talks to the datapath by command and status only.
module atan2h_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  atan2h_pkg::stat_t stat,
	output atan2h_pkg::cmd_t  cmd,
	output logic              busy
);

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_DT = 5'd1;
	localparam logic [4:0] S_WT = 5'd2;
	localparam logic [4:0] S_MT2 = 5'd3;
	localparam logic [4:0] S_DY = 5'd4;
	localparam logic [4:0] S_WY = 5'd5;
	localparam logic [4:0] S_DF = 5'd6;
	localparam logic [4:0] S_WF = 5'd7;
	localparam logic [4:0] S_D3 = 5'd8;
	localparam logic [4:0] S_W3 = 5'd9;
	localparam logic [4:0] S_CHK = 5'd10;
	localparam logic [4:0] S_MTY = 5'd11;
	localparam logic [4:0] S_MK = 5'd12;
	localparam logic [4:0] S_DK = 5'd13;
	localparam logic [4:0] S_WK = 5'd14;
	localparam logic [4:0] S_MSF = 5'd15;
	localparam logic [4:0] S_GA = 5'd16;
	localparam logic [4:0] S_RAD = 5'd17;
	localparam logic [4:0] S_MDEG = 5'd18;
	localparam logic [4:0] S_HEAD = 5'd19;

	logic [4:0] state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd.op = atan2h_pkg::OP_NONE;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.op = atan2h_pkg::OP_LOAD;
					state_d = S_DT;
				end
			end
			S_DT: begin
				if (stat.special) begin
					state_d = S_RAD;
				end else begin
					cmd.op = atan2h_pkg::OP_DIV_T;
					state_d = S_WT;
				end
			end
			S_WT: begin
				if (stat.div_done) begin
					cmd.op = atan2h_pkg::OP_GET_T;
					state_d = S_MT2;
				end
			end
			S_MT2: begin
				cmd.op = atan2h_pkg::OP_MUL_T2;
				state_d = S_DY;
			end
			S_DY: begin
				cmd.op = atan2h_pkg::OP_DIV_Y;
				state_d = S_WY;
			end
			S_WY: begin
				if (stat.div_done) begin
					cmd.op = atan2h_pkg::OP_GET_Y;
					state_d = S_DF;
				end
			end
			S_DF: begin
				cmd.op = atan2h_pkg::OP_DIV_F;
				state_d = S_WF;
			end
			S_WF: begin
				if (stat.div_done) begin
					cmd.op = atan2h_pkg::OP_GET_F;
					state_d = S_D3;
				end
			end
			S_D3: begin
				cmd.op = atan2h_pkg::OP_DIV_3;
				state_d = S_W3;
			end
			S_W3: begin
				cmd.op = atan2h_pkg::OP_GET_TERM0;
				state_d = S_CHK;
			end
			S_CHK: begin
				if (stat.k_end) begin
					state_d = S_MSF;
				end else begin
					cmd.op = atan2h_pkg::OP_ACC;
					state_d = stat.term_small ? S_MSF : S_MTY;
				end
			end
			S_MTY: begin
				cmd.op = atan2h_pkg::OP_MUL_TY;
				state_d = S_MK;
			end
			S_MK: begin
				cmd.op = atan2h_pkg::OP_MUL_K;
				state_d = S_DK;
			end
			S_DK: begin
				cmd.op = atan2h_pkg::OP_DIV_K;
				state_d = S_WK;
			end
			S_WK: begin
				if (stat.div_done) begin
					cmd.op = atan2h_pkg::OP_GET_TERM;
					state_d = S_CHK;
				end
			end
			S_MSF: begin
				cmd.op = atan2h_pkg::OP_MUL_SF;
				state_d = S_GA;
			end
			S_GA: begin
				cmd.op = atan2h_pkg::OP_GET_ATAN;
				state_d = S_RAD;
			end
			S_RAD: begin
				cmd.op = atan2h_pkg::OP_RAD;
				state_d = S_MDEG;
			end
			S_MDEG: begin
				cmd.op = atan2h_pkg::OP_MUL_DEG;
				state_d = S_HEAD;
			end
			S_HEAD: begin
				cmd.op = atan2h_pkg::OP_HEAD;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = state_q != S_IDLE;

endmodule
